// ===== hw/rtl/tgbe_pkg.sv =====
// Shared types and codes for the text gap buffer engine.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tgbe_pkg;

  localparam logic [20:0] NEWLINE_CODE = 21'd10;

  // Request codes
  typedef enum logic [3:0] {
    REQ_INSERT     = 4'd0,
    REQ_DEL_BEFORE = 4'd1,
    REQ_DEL_AFTER  = 4'd2,
    REQ_MOVE_BY    = 4'd3,
    REQ_MOVE_TO    = 4'd4,
    REQ_UP         = 4'd5,
    REQ_DOWN       = 4'd6,
    REQ_CLEAR      = 4'd7,
    REQ_READ       = 4'd8,
    REQ_LINE_NUM   = 4'd9,
    REQ_LINE_LEN   = 4'd10,
    REQ_LINE_START = 4'd11
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOEFF = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // Source of the query or character field of a result word
  typedef enum logic [2:0] {
    QS_NONE,
    QS_CNT,
    QS_CNT1,
    QS_IDX,
    QS_RCHAR
  } qsel_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_DEL_BEFORE,
    OP_DEL_AFTER,
    OP_CLEAR,
    OP_TGT_MOVE,
    OP_TGT_POS,
    OP_TGT_COL,
    OP_IDX_FRONT,
    OP_IDX_POS,
    OP_IDX_ZERO,
    OP_IDX_BACK1,
    OP_IDX_NEXT,
    OP_BASE_IDX,
    OP_RD_PREV,
    OP_RD_CUR,
    OP_BACK_STEP,
    OP_FWD_STEP,
    OP_CNT_STEP,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_BK_CHK,
    S_BK_WAIT,
    S_FW_CHK,
    S_FW_WAIT,
    S_NC_CHK,
    S_NC_WAIT,
    S_UP_A,
    S_UP_B,
    S_DN_A,
    S_DN_B,
    S_DN_C,
    S_COL,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_RD_ISSUE,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    stat_t stat;
    qsel_t qsel;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic gap_zero;
    logic del_b_zero;
    logic del_a_zero;
    logic pos_lt_len;
    logic pos_le_len;
    logic idx_zero;
    logic idx_lt_len;
    logic idx_lt_pos;
    logic is_nl;
    logic tgt_eq_front;
  } dp_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgbe_ctrl.sv =====
// Request sequencer of the text gap buffer engine.
// Depends on tgbe_pkg; drives tgbe_dp through a command word.
`timescale 1ns / 1ps
`default_nettype none

module tgbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tgbe_pkg::dp_flags_t flags,
  output tgbe_pkg::dp_cmd_t       cmd
);
  import tgbe_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;
  stat_t  st, st_next;
  qsel_t  qsel, qsel_next;
  logic   out_valid_next;

  // State and result bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      st        <= ST_NOEFF;
      qsel      <= QS_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      st        <= st_next;
      qsel      <= qsel_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and command
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    st_next        = st;
    qsel_next      = qsel;
    in_ready       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    cmd.op         = OP_NONE;
    cmd.stat       = st;
    cmd.qsel       = qsel;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          st_next    = ST_NOEFF;
          qsel_next  = QS_NONE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FIN;
        unique case (flags.req)
          REQ_INSERT: begin
            if (flags.gap_zero) begin
              st_next = ST_FULL;
            end else begin
              cmd.op  = OP_INSERT;
              st_next = ST_DONE;
            end
          end
          REQ_DEL_BEFORE: begin
            if (!flags.del_b_zero) begin
              cmd.op  = OP_DEL_BEFORE;
              st_next = ST_DONE;
            end
          end
          REQ_DEL_AFTER: begin
            if (!flags.del_a_zero) begin
              cmd.op  = OP_DEL_AFTER;
              st_next = ST_DONE;
            end
          end
          REQ_MOVE_BY: begin
            cmd.op     = OP_TGT_MOVE;
            state_next = S_SHIFT_CHK;
          end
          REQ_MOVE_TO: begin
            if (flags.pos_lt_len) begin
              cmd.op     = OP_TGT_POS;
              state_next = S_SHIFT_CHK;
            end
          end
          REQ_UP: begin
            cmd.op     = OP_IDX_FRONT;
            ret_next   = S_UP_A;
            state_next = S_BK_CHK;
          end
          REQ_DOWN: begin
            cmd.op     = OP_IDX_FRONT;
            ret_next   = S_DN_A;
            state_next = S_BK_CHK;
          end
          REQ_CLEAR: begin
            cmd.op  = OP_CLEAR;
            st_next = ST_DONE;
          end
          REQ_READ: begin
            if (flags.pos_lt_len) begin
              cmd.op     = OP_IDX_POS;
              state_next = S_RD_ISSUE;
            end
          end
          REQ_LINE_NUM: begin
            if (flags.pos_le_len) begin
              cmd.op     = OP_IDX_ZERO;
              st_next    = ST_DONE;
              qsel_next  = QS_CNT1;
              ret_next   = S_FIN;
              state_next = S_NC_CHK;
            end
          end
          REQ_LINE_LEN: begin
            if (flags.pos_le_len) begin
              cmd.op     = OP_IDX_POS;
              st_next    = ST_DONE;
              qsel_next  = QS_CNT;
              ret_next   = S_FIN;
              state_next = S_FW_CHK;
            end
          end
          REQ_LINE_START: begin
            if (flags.pos_le_len) begin
              cmd.op     = OP_IDX_POS;
              st_next    = ST_DONE;
              qsel_next  = QS_IDX;
              ret_next   = S_FIN;
              state_next = S_BK_CHK;
            end
          end
          default: ;
        endcase
      end
      // Walk back to the start of the line
      S_BK_CHK: begin
        if (flags.idx_zero) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_RD_PREV;
          state_next = S_BK_WAIT;
        end
      end
      S_BK_WAIT: begin
        if (flags.is_nl) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_BACK_STEP;
          state_next = S_BK_CHK;
        end
      end
      // Walk forward to the end of the line, counting
      S_FW_CHK: begin
        if (!flags.idx_lt_len) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_RD_CUR;
          state_next = S_FW_WAIT;
        end
      end
      S_FW_WAIT: begin
        if (flags.is_nl) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_FWD_STEP;
          state_next = S_FW_CHK;
        end
      end
      // Count newlines below the requested position
      S_NC_CHK: begin
        if (!flags.idx_lt_pos) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_RD_CUR;
          state_next = S_NC_WAIT;
        end
      end
      S_NC_WAIT: begin
        cmd.op     = OP_CNT_STEP;
        state_next = S_NC_CHK;
      end
      S_UP_A: begin
        if (flags.idx_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_IDX_BACK1;
          ret_next   = S_UP_B;
          state_next = S_BK_CHK;
        end
      end
      S_UP_B: begin
        cmd.op     = OP_BASE_IDX;
        ret_next   = S_COL;
        state_next = S_FW_CHK;
      end
      S_DN_A: begin
        cmd.op     = OP_BASE_IDX;
        ret_next   = S_DN_B;
        state_next = S_FW_CHK;
      end
      S_DN_B: begin
        cmd.op     = OP_IDX_NEXT;
        state_next = S_DN_C;
      end
      S_DN_C: begin
        if (flags.idx_lt_len) begin
          cmd.op     = OP_BASE_IDX;
          ret_next   = S_COL;
          state_next = S_FW_CHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_COL: begin
        cmd.op     = OP_TGT_COL;
        state_next = S_SHIFT_CHK;
      end
      // Move the gap one character at a time: a read, then a write
      S_SHIFT_CHK: begin
        if (flags.tgt_eq_front) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_SHIFT_RD;
          st_next    = ST_DONE;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.op     = OP_SHIFT_WR;
        state_next = S_SHIFT_CHK;
      end
      S_RD_ISSUE: begin
        cmd.op     = OP_RD_CUR;
        st_next    = ST_DONE;
        qsel_next  = QS_RCHAR;
        state_next = S_FIN;
      end
      // Hold the result until the output register is free
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tgbe_dp.sv =====
// Datapath of the text gap buffer engine: character store, gap registers,
// scan counters and the result register. Depends on tgbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgbe_dp #(
  parameter int CAPACITY = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tgbe_pkg::dp_cmd_t  cmd,
  output tgbe_pkg::dp_flags_t     flags,
  input  wire logic [3:0]         req_type,
  input  wire logic [20:0]        char_code,
  input  wire logic signed [13:0] step_delta,
  input  wire logic [12:0]        del_count,
  input  wire logic [12:0]        position,
  input  wire logic [12:0]        column,
  output logic [1:0]              status,
  output logic [20:0]             read_char,
  output logic [12:0]             query_value,
  output logic [12:0]             cursor_pos,
  output logic [12:0]             text_length
);
  import tgbe_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = CW + 1;
  localparam int WW = (XW > 14) ? XW : 14;
  localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

  logic [20:0] mem [CAPACITY];
  logic [20:0] rdata;

  logic [CW-1:0]   front, gap;
  logic [WW-1:0]   idx, cnt, base, tgt;
  logic [3:0]      req_r;
  logic [20:0]     code_r;
  logic signed [13:0] delta_r;
  logic [12:0]     dcnt_r, pos_r, col_r;

  logic [WW-1:0] front_w, gap_w, len_w, back_w, pos_w, col_w, dcnt_w;
  logic [WW-1:0] mag_w, t_b, t_a, tgt_move, col_clamp, idx_m1;
  logic [WW-1:0] phys_cur, phys_prev, src_l, src_r;
  logic [13:0]   mag;
  logic          tgt_lt_front;
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [20:0]   wdata;

  // Common operands
  always_comb begin
    front_w   = WW'(front);
    gap_w     = WW'(gap);
    len_w     = CAP_W - gap_w;
    back_w    = len_w - front_w;
    pos_w     = WW'(pos_r);
    col_w     = WW'(col_r);
    dcnt_w    = WW'(dcnt_r);
    mag       = delta_r[13] ? 14'(-delta_r) : 14'(delta_r);
    mag_w     = WW'(mag);
    t_b       = (dcnt_w < front_w) ? dcnt_w : front_w;
    t_a       = (dcnt_w < back_w) ? dcnt_w : back_w;
    tgt_move  = delta_r[13] ? front_w - ((mag_w < front_w) ? mag_w : front_w)
                            : front_w + ((mag_w < back_w) ? mag_w : back_w);
    col_clamp = base + ((col_w < cnt) ? col_w : cnt);
    idx_m1    = idx - WW'(1);
    phys_cur  = (idx < front_w) ? idx : idx + gap_w;
    phys_prev = (idx_m1 < front_w) ? idx_m1 : idx_m1 + gap_w;
    src_l     = front_w - WW'(1);
    src_r     = front_w + gap_w;
    tgt_lt_front = tgt < front_w;
  end

  // Store port selection
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = phys_cur[AW-1:0];
    waddr = front_w[AW-1:0];
    wdata = rdata;
    case (cmd.op)
      OP_RD_CUR: re = 1'b1;
      OP_RD_PREV: begin
        re    = 1'b1;
        raddr = phys_prev[AW-1:0];
      end
      OP_SHIFT_RD: begin
        re    = 1'b1;
        raddr = tgt_lt_front ? src_l[AW-1:0] : src_r[AW-1:0];
      end
      OP_SHIFT_WR: begin
        we    = 1'b1;
        waddr = tgt_lt_front ? idx[AW-1:0] : front_w[AW-1:0];
      end
      OP_INSERT: begin
        we    = 1'b1;
        wdata = code_r;
      end
      default: ;
    endcase
  end

  // Character store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Gap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      gap   <= CW'(CAPACITY);
    end else begin
      case (cmd.op)
        OP_INSERT: begin
          front <= front + CW'(1);
          gap   <= gap - CW'(1);
        end
        OP_DEL_BEFORE: begin
          front <= front - CW'(t_b);
          gap   <= gap + CW'(t_b);
        end
        OP_DEL_AFTER: gap <= gap + CW'(t_a);
        OP_CLEAR: begin
          front <= '0;
          gap   <= CW'(CAPACITY);
        end
        OP_SHIFT_WR: front <= tgt_lt_front ? front - CW'(1) : front + CW'(1);
        default: ;
      endcase
    end
  end

  // Request capture and scan registers; idx holds front+gap-1 during a left shift
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r   <= req_type;
        code_r  <= char_code;
        delta_r <= step_delta;
        dcnt_r  <= del_count;
        pos_r   <= position;
        col_r   <= column;
      end
      OP_TGT_MOVE:  tgt <= tgt_move;
      OP_TGT_POS:   tgt <= pos_w;
      OP_TGT_COL:   tgt <= col_clamp;
      OP_IDX_FRONT: idx <= front_w;
      OP_IDX_POS: begin
        idx <= pos_w;
        cnt <= '0;
      end
      OP_IDX_ZERO: begin
        idx <= '0;
        cnt <= '0;
      end
      OP_IDX_BACK1: idx <= idx_m1;
      OP_IDX_NEXT:  idx <= idx + WW'(1);
      OP_BASE_IDX: begin
        base <= idx;
        cnt  <= '0;
      end
      OP_BACK_STEP: idx <= idx_m1;
      OP_FWD_STEP: begin
        idx <= idx + WW'(1);
        cnt <= cnt + WW'(1);
      end
      OP_CNT_STEP: begin
        idx <= idx + WW'(1);
        cnt <= cnt + WW'(rdata == NEWLINE_CODE);
      end
      OP_SHIFT_RD: idx <= src_r - WW'(1);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      status      <= cmd.stat;
      read_char   <= (cmd.qsel == QS_RCHAR) ? rdata : 21'd0;
      text_length <= len_w[12:0];
      cursor_pos  <= front_w[12:0];
      case (cmd.qsel)
        QS_CNT:  query_value <= cnt[12:0];
        QS_CNT1: query_value <= 13'(cnt + WW'(1));
        QS_IDX:  query_value <= idx[12:0];
        default: query_value <= 13'd0;
      endcase
    end
  end

  // Status toward the sequencer
  always_comb begin
    flags.req          = req_t'(req_r);
    flags.gap_zero     = gap == '0;
    flags.del_b_zero   = t_b == '0;
    flags.del_a_zero   = t_a == '0;
    flags.pos_lt_len   = pos_w < len_w;
    flags.pos_le_len   = pos_w <= len_w;
    flags.idx_zero     = idx == '0;
    flags.idx_lt_len   = idx < len_w;
    flags.idx_lt_pos   = idx < pos_w;
    flags.is_nl        = rdata == NEWLINE_CODE;
    flags.tgt_eq_front = tgt == front_w;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_gap_buffer_engine_unit.sv =====
// Text gap buffer engine: character store with a cursor at the gap.
// One request word in, one result word out per request.
// Input channel in_valid/in_ready carries req_type and its operands; output
// channel out_valid/out_ready carries status, read_char, query_value,
// cursor_pos and text_length.
// One request is worked at a time; the next is taken once the current
// result is placed in the output register, which may still wait for the
// receiver.
// Steps: insert, delete and clear pass through load, dispatch and finish.
// A cursor move adds one read and one write of the store for each
// character the gap moves. Line scans (up, down, line queries) add a
// read and a check for each character visited; a read adds one store
// read before the finish.
// Reset empties the text and puts the cursor at 0; the store
// itself is not cleared. A stalled receiver holds the result in the output
// register and stops the sequencer before it writes the next result.
`timescale 1ns / 1ps
`default_nettype none

module text_gap_buffer_engine_unit #(
  parameter int CAPACITY = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         req_type,
  input  wire logic [20:0]        char_code,
  input  wire logic signed [13:0] step_delta,
  input  wire logic [12:0]        del_count,
  input  wire logic [12:0]        position,
  input  wire logic [12:0]        column,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [20:0]             read_char,
  output logic [12:0]             query_value,
  output logic [12:0]             cursor_pos,
  output logic [12:0]             text_length
);
  import tgbe_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // Sequencer
  tgbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Store and arithmetic
  tgbe_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flags       (flags),
    .req_type    (req_type),
    .char_code   (char_code),
    .step_delta  (step_delta),
    .del_count   (del_count),
    .position    (position),
    .column      (column),
    .status      (status),
    .read_char   (read_char),
    .query_value (query_value),
    .cursor_pos  (cursor_pos),
    .text_length (text_length)
  );

endmodule

`default_nettype wire

// ===== verif/text_gap_buffer_engine_unit_test.sv =====
// Self-checking testbench for text_gap_buffer_engine_unit.
// Depends on tgbe_pkg (request and status codes) and the unit's RTL only.
`timescale 1ns / 1ps

module text_gap_buffer_engine_unit_test;
  import tgbe_pkg::*;

  localparam int CAP = 4096;

  typedef struct packed {
    logic [1:0]  st;
    logic [20:0] rc;
    logic [12:0] qv;
    logic [12:0] cur;
    logic [12:0] len;
  } text_result_t;

  // Gap buffer predictor plus the queue of result words still owed
  class gap_text_scoreboard;
    logic [20:0]  store [CAP];
    int           front;
    int           gap;
    text_result_t owed [$];
    int           errors;
    int           matched;

    function new();
      foreach (store[i]) store[i] = '0;
      front = 0;
      gap = CAP;
      errors = 0;
      matched = 0;
    endfunction

    function int text_len();
      return CAP - gap;
    endfunction

    function logic [20:0] char_at(int idx);
      int phys;
      phys = (idx < front) ? idx : idx + gap;
      if (phys >= CAP) return '0;
      return store[phys];
    endfunction

    // Move the gap so the cursor lands on target; report whether it moved
    function bit shift_to(int target);
      int i;
      if (target < front) begin
        for (i = front - 1; i >= target; i--) store[i + gap] = store[i];
        front = target;
        return 1;
      end
      if (target > front) begin
        for (i = front; i < target; i++) store[i] = store[i + gap];
        front = target;
        return 1;
      end
      return 0;
    endfunction

    function int line_start_of(int idx);
      while (idx > 0 && char_at(idx - 1) != NEWLINE_CODE) idx--;
      return idx;
    endfunction

    function int line_len_of(int idx);
      int n;
      n = 0;
      while (idx < text_len() && char_at(idx) != NEWLINE_CODE) begin
        n++;
        idx++;
      end
      return n;
    endfunction

    function int line_num_of(int idx);
      int n;
      n = 1;
      for (int i = 0; i < idx; i++) if (char_at(i) == NEWLINE_CODE) n++;
      return n;
    endfunction

    // Apply one accepted request and queue the word it must produce
    function void note_request(logic [3:0] req, logic [20:0] code,
                               logic signed [13:0] delta, logic [12:0] cnt,
                               logic [12:0] pos, logic [12:0] col);
      int           d, len, back, a, b, t;
      logic [1:0]   st;
      logic [20:0]  rc;
      int           qv;
      text_result_t r;
      d = int'(delta);
      len = text_len();
      back = len - front;
      st = ST_NOEFF;
      rc = '0;
      qv = 0;
      case (req)
        REQ_INSERT: begin
          if (gap == 0) st = ST_FULL;
          else begin
            store[front] = code;
            front++;
            gap--;
            st = ST_DONE;
          end
        end
        REQ_DEL_BEFORE: begin
          t = (cnt < front) ? cnt : front;
          if (t > 0) begin
            front -= t;
            gap += t;
            st = ST_DONE;
          end
        end
        REQ_DEL_AFTER: begin
          t = (cnt < back) ? cnt : back;
          if (t > 0) begin
            gap += t;
            st = ST_DONE;
          end
        end
        REQ_MOVE_BY: begin
          if (d < 0) begin
            a = -d;
            t = front - ((a < front) ? a : front);
          end else begin
            t = front + ((d < back) ? d : back);
          end
          st = shift_to(t) ? ST_DONE : ST_NOEFF;
        end
        REQ_MOVE_TO: begin
          if (pos < len) st = shift_to(pos) ? ST_DONE : ST_NOEFF;
        end
        REQ_UP: begin
          a = line_start_of(front);
          if (a > 0) begin
            b = line_start_of(a - 1);
            t = line_len_of(b);
            st = shift_to(b + ((col < t) ? col : t)) ? ST_DONE : ST_NOEFF;
          end
        end
        REQ_DOWN: begin
          a = line_start_of(front);
          b = a + line_len_of(a) + 1;
          if (b < len) begin
            t = line_len_of(b);
            st = shift_to(b + ((col < t) ? col : t)) ? ST_DONE : ST_NOEFF;
          end
        end
        REQ_CLEAR: begin
          front = 0;
          gap = CAP;
          st = ST_DONE;
        end
        REQ_READ: begin
          if (pos < len) begin
            rc = char_at(pos);
            st = ST_DONE;
          end
        end
        REQ_LINE_NUM, REQ_LINE_LEN, REQ_LINE_START: begin
          if (pos <= len) begin
            if (req == REQ_LINE_NUM) qv = line_num_of(pos);
            else if (req == REQ_LINE_LEN) qv = line_len_of(pos);
            else qv = line_start_of(pos);
            st = ST_DONE;
          end
        end
        default: st = ST_NOEFF;
      endcase
      r.st = st;
      r.rc = rc;
      r.qv = qv[12:0];
      r.cur = front[12:0];
      r.len = 13'(text_len());
      owed.push_back(r);
    endfunction

    function void report(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one delivered word with the oldest owed one
    function void check_result(text_result_t act);
      text_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word, status %0d", $time, act.st);
        errors++;
        return;
      end
      e = owed.pop_front();
      report("status", e.st, act.st);
      report("read_char", e.rc, act.rc);
      report("query_value", e.qv, act.qv);
      report("cursor_pos", e.cur, act.cur);
      report("text_length", e.len, act.len);
      matched++;
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         req_type;
  logic [20:0]        char_code;
  logic signed [13:0] step_delta;
  logic [12:0]        del_count;
  logic [12:0]        position;
  logic [12:0]        column;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [20:0]        read_char;
  logic [12:0]        query_value;
  logic [12:0]        cursor_pos;
  logic [12:0]        text_length;

  gap_text_scoreboard sb;
  bit                 quiet;
  int                 sent;

  text_gap_buffer_engine_unit #(.CAPACITY(CAP)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .char_code(char_code), .step_delta(step_delta),
    .del_count(del_count), .position(position), .column(column),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .read_char(read_char), .query_value(query_value),
    .cursor_pos(cursor_pos), .text_length(text_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one request word and hold it until accepted
  task automatic send(logic [3:0] req, logic [20:0] code = 21'd0,
                      logic signed [13:0] delta = 14'sd0,
                      logic [12:0] cnt = 13'd0, logic [12:0] pos = 13'd0,
                      logic [12:0] col = 13'd0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    char_code <= code;
    step_delta <= delta;
    del_count <= cnt;
    position <= pos;
    column <= col;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, code, delta, cnt, pos, col);
    sent++;
  endtask

  function automatic logic [20:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return NEWLINE_CODE;
      2: return 21'($urandom);
      default: return 21'($urandom_range(32, 126));
    endcase
  endfunction

  // Random request with operands biased toward the current text
  task automatic send_random();
    int          r;
    int          len;
    logic [12:0] pos;
    logic [12:0] cnt;
    logic [12:0] col;
    logic [13:0] delta;
    r = $urandom_range(0, 99);
    len = sb.text_len();
    pos = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, len + 2));
    cnt = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 6));
    col = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 12));
    delta = ($urandom_range(0, 7) == 0) ? 14'($urandom)
                                         : 14'($signed($urandom_range(0, 24)) - 12);
    if (r < 40) send(REQ_INSERT, pick_char());
    else if (r < 46) send(REQ_DEL_BEFORE, 21'($urandom), 14'd0, cnt);
    else if (r < 52) send(REQ_DEL_AFTER, 21'd0, 14'd0, cnt);
    else if (r < 62) send(REQ_MOVE_BY, 21'd0, delta);
    else if (r < 70) send(REQ_MOVE_TO, 21'd0, 14'd0, 13'd0, pos);
    else if (r < 76) send(REQ_UP, 21'd0, 14'd0, 13'd0, 13'd0, col);
    else if (r < 82) send(REQ_DOWN, 21'd0, 14'd0, 13'd0, 13'd0, col);
    else if (r < 85) send(REQ_CLEAR);
    else if (r < 90) send(REQ_READ, 21'd0, 14'd0, 13'd0, pos);
    else if (r < 93) send(REQ_LINE_NUM, 21'd0, 14'd0, 13'd0, pos);
    else if (r < 96) send(REQ_LINE_LEN, 21'd0, 14'd0, 13'd0, pos);
    else if (r < 99) send(REQ_LINE_START, 21'd0, 14'd0, 13'd0, pos);
    else send(4'($urandom_range(12, 15)), 21'($urandom), 14'($urandom),
              13'($urandom), 13'($urandom), 13'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off, steady ready at the end
  initial begin
    int cyc;
    int n;
    cyc = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (cyc > 3000 && cyc < 100000) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc = 100000;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
        cyc += n;
      end
    end
  end

  // Check every delivered result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({status, read_char, query_value, cursor_pos, text_length});
  end

  initial begin
    #20_000_000;
    $display("text_gap_buffer_engine_unit: mismatch");
    $finish;
  end

  initial begin
    int len;
    sb = new();
    quiet = 0;
    sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= '0;
    char_code <= '0;
    step_delta <= '0;
    del_count <= '0;
    position <= '0;
    column <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and the clamped or ignored cases
    send(REQ_DEL_BEFORE, 21'd0, 14'd0, 13'd1);
    send(REQ_INSERT, 21'd97);
    send(REQ_INSERT, NEWLINE_CODE);
    send(REQ_INSERT, 21'h1FFFFF);
    send(REQ_INSERT, 21'd0);
    send(REQ_READ, 21'd0, 14'd0, 13'd0, 13'd0);
    send(REQ_READ, 21'd0, 14'd0, 13'd0, 13'd4);
    send(REQ_READ, 21'd0, 14'd0, 13'd0, 13'h1FFF);
    send(REQ_UP, 21'd0, 14'd0, 13'd0, 13'd0, 13'h1FFF);
    send(REQ_UP);
    send(REQ_DOWN, 21'd0, 14'd0, 13'd0, 13'd0, 13'h1FFF);
    send(REQ_DOWN);
    send(REQ_MOVE_BY, 21'd0, 14'sh2000);
    send(REQ_MOVE_BY, 21'd0, 14'sh1FFF);
    send(REQ_MOVE_BY, 21'd0, 14'sd0);
    send(REQ_MOVE_TO, 21'd0, 14'd0, 13'd0, 13'd4);
    send(REQ_MOVE_TO, 21'd0, 14'd0, 13'd0, 13'd1);
    send(REQ_LINE_NUM, 21'd0, 14'd0, 13'd0, 13'd4);
    send(REQ_LINE_LEN, 21'd0, 14'd0, 13'd0, 13'd0);
    send(REQ_LINE_START, 21'd0, 14'd0, 13'd0, 13'd4);
    send(REQ_LINE_NUM, 21'd0, 14'd0, 13'd0, 13'h1FFF);
    send(REQ_DEL_AFTER, 21'd0, 14'd0, 13'h1FFF);
    send(REQ_DEL_BEFORE, 21'd0, 14'd0, 13'h1FFF);
    send(4'd15, 21'h1FFFFF, 14'sh1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    send(REQ_CLEAR);

    // Fill to capacity, then work the full buffer
    for (int i = 0; i < CAP; i++) send(REQ_INSERT, pick_char());
    send(REQ_INSERT, 21'd65);
    send(REQ_MOVE_TO, 21'd0, 14'd0, 13'd0, 13'd0);
    send(REQ_DOWN, 21'd0, 14'd0, 13'd0, 13'd0, 13'd5);
    send(REQ_LINE_NUM, 21'd0, 14'd0, 13'd0, 13'(CAP));
    send(REQ_LINE_START, 21'd0, 14'd0, 13'd0, 13'(CAP));
    send(REQ_MOVE_BY, 21'd0, 14'sd4096);
    send(REQ_DEL_BEFORE, 21'd0, 14'd0, 13'd1);
    send(REQ_INSERT, 21'd66);
    send(REQ_INSERT, 21'd67);
    send(REQ_CLEAR);

    // Random mix; the tail runs with no idling on either side
    for (int i = 0; i < 2000; i++) begin
      if (i == 1800) quiet = 1;
      send_random();
    end
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    len = sb.text_len();
    $display("Sent %0d requests (directed, fill to capacity, random mix); %0d results checked.",
             sent, sb.matched);
    $display("Final text length %0d, errors %0d.", len, sb.errors);
    if (sb.errors == 0)
      $display("text_gap_buffer_engine_unit: match");
    else
      $display("text_gap_buffer_engine_unit: mismatch");
    $finish;
  end

endmodule
